/* rtl/spwm_pkg.sv */
`default_nettype none
package spwm_pkg;

    localparam int unsigned DIV_W = 42;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int unsigned DVR_W = 10;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_BURST = 3'd4;

    localparam logic [11:0] FULL_SCALE = 12'd3600;
    localparam logic [12:0] DEAD_COUNT = 13'd360;
    localparam logic [12:0] TEMP_HIGH  = 13'd3240;
    localparam logic [12:0] AMP_SCALE  = 13'd12;
    localparam logic [9:0]  MAX_POINTS = 10'd512;
    localparam logic [9:0]  MIN_POINTS = 10'd2;
    localparam logic [9:0]  RST_POINTS = 10'd100;
    localparam logic [8:0]  RST_AMP    = 9'd220;
    localparam logic [15:0] RST_BURST  = 16'd25;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [2:0]  LAST_TERM  = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [9:0] new_points;
        logic [8:0] new_amplitude;
    } t_in;

    typedef struct packed {
        logic [11:0] compare_a;
        logic [11:0] compare_b;
        logic        outputs_enabled;
    } t_out;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SINE,
        T_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        SN_IDLE,
        SN_XDIV,
        SN_X2,
        SN_MUL,
        SN_TSTART,
        SN_TDIV,
        SN_ROUND
    } t_sine_state;

    // Taylor denominators j*(j+1) for j = 2, 4, ..., 12.
    function automatic logic [DVR_W-1:0] taylor_div(input logic [2:0] step);
        logic [DVR_W-1:0] d;
        unique case (step)
            3'd0:    d = 10'd6;
            3'd1:    d = 10'd20;
            3'd2:    d = 10'd42;
            3'd3:    d = 10'd72;
            3'd4:    d = 10'd110;
            3'd5:    d = 10'd156;
            default: d = 10'd1;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

/* rtl/spwm_div.sv */
`default_nettype none
module spwm_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [spwm_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [spwm_pkg::DVR_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [spwm_pkg::DIV_W-1:0]       o_quotient
);
    import spwm_pkg::*;

    // Restoring divider: one quotient bit per cycle, MSB first.
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DVR_W-1:0]     r_rem, n_rem;
    logic [DVR_W-1:0]     r_dvr, n_dvr;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DVR_W:0]       trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvr  = r_dvr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[DIV_W-1]};
        if (r_busy) begin
            if (trial >= {1'b0, r_dvr}) begin
                n_rem = DVR_W'(trial - {1'b0, r_dvr});
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DVR_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = DIV_CNT_W'(r_cnt - 1'b1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvr  = i_divisor;
            n_cnt  = DIV_CNT_W'(DIV_W);
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvr <= n_dvr;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* rtl/spwm_sine.sv */
`default_nettype none
module spwm_sine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [9:0]  i_k,
    input  wire logic [9:0]  i_n,
    output logic             o_done,
    output logic [14:0]      o_sine
);
    import spwm_pkg::*;

    t_sine_state r_state, n_state;
    logic [31:0] r_x, n_x;
    logic [31:0] r_x2, n_x2;
    logic [31:0] r_term, n_term;
    logic [31:0] r_sum, n_sum;
    logic [32:0] r_prod, n_prod;
    logic [2:0]  r_step, n_step;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DVR_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;

    logic [10:0] m2, m1;
    logic [9:0]  m;
    logic [63:0] sq, tp;
    logic [32:0] rnd;
    logic [31:0] q32;

    spwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_x2         = r_x2;
        n_term       = r_term;
        n_sum        = r_sum;
        n_prod       = r_prod;
        n_step       = r_step;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = i_n;
        o_done       = 1'b0;
        o_sine       = '0;

        // Fold the angle into the first quarter period.
        m2 = {i_k, 1'b0};
        m1 = (m2 > {1'b0, i_n}) ? 11'd0 : m2;
        m  = ({m1, 1'b0} > {2'b0, i_n}) ? 10'(i_n - m1[9:0]) : m1[9:0];

        sq  = 64'(r_x) * 64'(r_x);
        tp  = 64'(r_term) * 64'(r_x2);
        rnd = 33'(r_sum) + 33'd16384;
        q32 = div_quo[31:0];

        unique case (r_state)
            SN_IDLE: begin
                if (i_start) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(PI_Q30) * DIV_W'(m);
                    div_divisor  = i_n;
                    n_state      = SN_XDIV;
                end
            end
            SN_XDIV: begin
                if (div_done) begin
                    n_x     = q32;
                    n_term  = q32;
                    n_sum   = q32;
                    n_state = SN_X2;
                end
            end
            SN_X2: begin
                n_x2    = sq[61:30];
                n_step  = '0;
                n_state = SN_MUL;
            end
            SN_MUL: begin
                n_prod  = tp[62:30];
                n_state = SN_TSTART;
            end
            SN_TSTART: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_prod);
                div_divisor  = taylor_div(r_step);
                n_state      = SN_TDIV;
            end
            SN_TDIV: begin
                if (div_done) begin
                    n_term = q32;
                    // Terms alternate in sign, starting with a subtraction.
                    if (!r_step[0]) begin
                        n_sum = (r_sum > q32) ? 32'(r_sum - q32) : 32'd0;
                    end else begin
                        n_sum = 32'(r_sum + q32);
                    end
                    if (r_step == LAST_TERM) begin
                        n_state = SN_ROUND;
                    end else begin
                        n_step  = 3'(r_step + 1'b1);
                        n_state = SN_MUL;
                    end
                end
            end
            SN_ROUND: begin
                o_done  = 1'b1;
                o_sine  = (rnd[32:15] > 18'd32767) ? 15'd32767 : rnd[29:15];
                n_state = SN_IDLE;
            end
            default: n_state = SN_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_x2   <= n_x2;
        r_term <= n_term;
        r_sum  <= n_sum;
        r_prod <= n_prod;
        r_step <= n_step;
        if (!i_rst_n) begin
            r_state <= SN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* rtl/spwm_compare_sequencer.sv */
`default_nettype none
// Control words, stopped ticks and ticks with both legs off give their result in the cycle after they are accepted.
// A running tick that drives a leg waits for the sine unit, which runs seven divisions
// on its bit-serial divider.
// One word is in work at a time; the next is accepted once its result is registered and the output is not stalled.
// Reset (synchronous, active low) restores the default settings with outputs off.
module spwm_compare_sequencer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire spwm_pkg::t_in    i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output spwm_pkg::t_out        o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [15:0]      i_cfg_data
);
    import spwm_pkg::*;

    t_top_state  r_state, n_state;
    logic [9:0]  r_pos, n_pos;
    logic [9:0]  r_act_pts, n_act_pts;
    logic [8:0]  r_act_amp, n_act_amp;
    logic [9:0]  r_pend_pts, n_pend_pts;
    logic [8:0]  r_pend_amp, n_pend_amp;
    logic        r_pend_v, n_pend_v;
    logic        r_run, n_run;
    logic        r_burst, n_burst;
    logic [15:0] r_bcount, n_bcount;
    logic [15:0] r_bperiods;
    logic [11:0] r_held_a, n_held_a;
    logic [11:0] r_held_b, n_held_b;
    logic        r_leg_b, n_leg_b;
    logic [12:0] r_temp, n_temp;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic        slot_free, accept;
    logic        sine_start, sine_done;
    logic [9:0]  sine_k;
    logic [14:0] sine_s;

    logic [9:0]  p, pts, half, np, idx;
    logic [15:0] bc1;
    logic        leg_a, leg_b;
    logic [12:0] amp12;
    logic [27:0] tprod;
    logic [11:0] onv;

    // The sine unit samples the point count only on its start cycle, so it gets the
    // count that holds after a period wrap.
    spwm_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sine_start),
        .i_k     (sine_k),
        .i_n     (pts),
        .o_done  (sine_done),
        .o_sine  (sine_s)
    );

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && (r_state == T_IDLE) && slot_free;
    assign o_in_stall = !((r_state == T_IDLE) && slot_free);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_act_pts   = r_act_pts;
        n_act_amp   = r_act_amp;
        n_pend_pts  = r_pend_pts;
        n_pend_amp  = r_pend_amp;
        n_pend_v    = r_pend_v;
        n_run       = r_run;
        n_burst     = r_burst;
        n_bcount    = r_bcount;
        n_held_a    = r_held_a;
        n_held_b    = r_held_b;
        n_leg_b     = r_leg_b;
        n_temp      = r_temp;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        sine_start  = 1'b0;

        p     = r_pos;
        pts   = r_act_pts;
        bc1   = 16'(r_bcount + 1'b1);
        half  = '0;
        leg_a = 1'b0;
        leg_b = 1'b0;
        idx   = '0;
        np    = i_in.new_points;
        amp12 = 13'(r_act_amp) * AMP_SCALE;
        tprod = 28'(amp12) * 28'(sine_s);

        if (r_temp != '0 && r_temp < DEAD_COUNT) begin
            onv = 12'(13'(FULL_SCALE) - DEAD_COUNT);
        end else if (r_temp > TEMP_HIGH) begin
            onv = '0;
        end else begin
            onv = 12'(13'(FULL_SCALE) - r_temp);
        end

        unique case (r_state)
            T_IDLE: begin
                if (accept) begin
                    priority if (i_in.op == OP_TICK && r_run) begin
                        if (r_pos >= r_act_pts) begin
                            if (r_burst) begin
                                n_bcount = bc1;
                                if (bc1 >= r_bperiods) begin
                                    n_run    = 1'b0;
                                    n_burst  = 1'b0;
                                    n_bcount = '0;
                                end
                            end
                            p = '0;
                            if (r_pend_v) begin
                                pts       = r_pend_pts;
                                n_act_pts = r_pend_pts;
                                n_act_amp = r_pend_amp;
                                n_pend_v  = 1'b0;
                            end
                        end
                        half  = {1'b0, pts[9:1]};
                        leg_a = p < half;
                        leg_b = !leg_a && (10'(p - half) < half);
                        idx   = leg_a ? p : 10'(p - half);
                        n_pos = 10'(p + 1'b1);
                        if (leg_a || leg_b) begin
                            // Both settings and position are now fixed for this tick.
                            sine_start = 1'b1;
                            n_leg_b    = leg_b;
                            n_state    = T_SINE;
                        end else begin
                            n_held_a    = FULL_SCALE;
                            n_held_b    = FULL_SCALE;
                            n_out_valid = 1'b1;
                            n_out       = '{FULL_SCALE, FULL_SCALE, n_run};
                        end
                    end else begin
                        if (i_in.op == OP_START) begin
                            n_run = 1'b1;
                        end else if (i_in.op == OP_STOP) begin
                            n_run = 1'b0;
                        end else if (i_in.op == OP_SET) begin
                            if (np < MIN_POINTS) np = MIN_POINTS;
                            if (np > MAX_POINTS) np = MAX_POINTS;
                            n_pend_pts = np;
                            n_pend_amp = i_in.new_amplitude;
                            n_pend_v   = 1'b1;
                        end else if (i_in.op == OP_BURST) begin
                            n_burst  = 1'b1;
                            n_bcount = '0;
                            n_run    = 1'b1;
                        end
                        n_out_valid = 1'b1;
                        n_out       = '{r_held_a, r_held_b, n_run};
                    end
                end
            end
            T_SINE: begin
                if (sine_done) begin
                    n_temp  = tprod[27:15];
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                if (slot_free) begin
                    n_held_a    = r_leg_b ? FULL_SCALE : onv;
                    n_held_b    = r_leg_b ? onv : FULL_SCALE;
                    n_out_valid = 1'b1;
                    n_out       = '{n_held_a, n_held_b, r_run};
                    n_state     = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase

        sine_k = 10'(idx + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        r_leg_b <= n_leg_b;
        r_temp  <= n_temp;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_pos       <= '0;
            r_act_pts   <= RST_POINTS;
            r_act_amp   <= '0;
            r_pend_pts  <= RST_POINTS;
            r_pend_amp  <= RST_AMP;
            r_pend_v    <= 1'b1;
            r_run       <= 1'b0;
            r_burst     <= 1'b0;
            r_bcount    <= '0;
            r_bperiods  <= RST_BURST;
            r_held_a    <= FULL_SCALE;
            r_held_b    <= FULL_SCALE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_act_pts   <= n_act_pts;
            r_act_amp   <= n_act_amp;
            r_pend_pts  <= n_pend_pts;
            r_pend_amp  <= n_pend_amp;
            r_pend_v    <= n_pend_v;
            r_run       <= n_run;
            r_burst     <= n_burst;
            r_bcount    <= n_bcount;
            r_held_a    <= n_held_a;
            r_held_b    <= n_held_b;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_bperiods <= i_cfg_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
